FILE: rtl/ccc_pkg.sv
// Shared constants, field widths and request codes for the connected
// component counter. No dependencies; imported by the top level.
package ccc_pkg;

  // Default graph size (nodes per graph, one adjacency row per node)
  localparam int unsigned MAX_NODES_DEF = 64;

  // Field widths of the stream beats
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned NODE_W    = 7;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 8;

  // Register port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [NODE_W-1:0] NODE_COUNT_RST = 7'd64;

  // Register index decoded from paddr[2]
  localparam logic REG_NODE_COUNT = 1'b0;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD   = 2'd0,
    REQ_COUNT = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

endpackage

FILE: rtl/connected_component_counter_top.sv
// Connected component counter: adjacency bit matrix, walk stack and the
// sequencer that drives one shared chunk search unit. Depends on ccc_pkg.
//
// Overview for users of the block
// -------------------------------
// Keeps an undirected graph on nodes 1..node_count as a MAX_NODES x MAX_NODES
// bit matrix in a single-port-write, registered-read memory. Each input beat is
// a request: add an edge (sets both symmetric bits), count components (emits
// one output beat with the number of depth-first walks needed to cover nodes
// 1..node_count), or clear the graph. Edges with an endpoint of 0 or above the
// nodes in use are dropped. node_count above MAX_NODES acts as MAX_NODES.
//
// Request handling (CH = ceil(MAX_NODES/8) chunks of eight node bits):
//   - after reset the adjacency memory is swept to zero, one row a cycle,
//     while s_axis_tready stays low (register writes are taken as usual)
//   - add edge: two read-modify-write row updates on the one memory port;
//     a dropped edge or an unused request code is taken without further steps
//   - clear graph: same sweep as after reset
//   - count: every popped node costs one stack read, one row read and a scan
//     of the row over CH chunks; each cycle of the scan the shared unit picks
//     the lowest pending bit of one chunk.
// The result sits in an output register, so the next request is taken while
// the count still waits for m_axis_tready.
module connected_component_counter_top #(
  parameter int unsigned MAX_NODES = ccc_pkg::MAX_NODES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Request stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [1:0] req_type, [8:2] node_a, [15:9] node_b
  input  logic [ccc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [6:0] component_count, [7] zero
  output logic [ccc_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // Register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ccc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ccc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ccc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  import ccc_pkg::*;

  // Node index, count and chunk geometry all follow MAX_NODES
  localparam int unsigned NW  = $clog2(MAX_NODES);
  localparam int unsigned CW  = $clog2(MAX_NODES + 1);
  localparam int unsigned WW  = (CW > NODE_W) ? CW : NODE_W;
  localparam int unsigned CK  = (MAX_NODES >= 8) ? 8 : (1 << $clog2(MAX_NODES));
  localparam int unsigned PBW = $clog2(CK);
  localparam int unsigned NC  = (MAX_NODES + CK - 1) / CK;
  localparam int unsigned CIW = (NC > 1) ? $clog2(NC) : 1;
  localparam int unsigned PW  = NC * CK;

  typedef logic [NW-1:0]        node_t;
  typedef logic [MAX_NODES-1:0] row_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_RD_A,
    S_ADD_WR_A,
    S_ADD_RD_B,
    S_ADD_WR_B,
    S_FIND,
    S_POP,
    S_ROW,
    S_LOAD,
    S_SCAN,
    S_EMIT
  } state_e;

  state_e              state_q;
  logic [NODE_W-1:0]   node_count_q;
  node_t               a_q, b_q;
  node_t               clr_idx_q;
  row_t                visited_q;
  row_t                cand_q;
  logic [CW-1:0]       sp_q;
  logic [CW-1:0]       cnt_q;
  logic [CIW-1:0]      find_idx_q;
  logic [CIW-1:0]      scan_idx_q;
  logic                m_tvalid_q;
  logic [COUNT_W-1:0]  m_tdata_q;

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  logic [REQ_W-1:0]  in_req;
  logic [NODE_W-1:0] in_a, in_b;
  logic              in_acc;

  assign in_req = s_axis_tdata[REQ_W-1:0];
  assign in_a   = s_axis_tdata[REQ_W +: NODE_W];
  assign in_b   = s_axis_tdata[REQ_W + NODE_W +: NODE_W];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Nodes in use: node_count clipped to MAX_NODES
  logic [WW-1:0] nc_ext;
  logic [CW-1:0] n_eff;

  assign nc_ext = WW'(node_count_q);
  assign n_eff  = (nc_ext > WW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(nc_ext);

  // One bit per node below the nodes-in-use limit
  row_t range_mask;
  for (genvar gi = 0; gi < MAX_NODES; gi++) begin : g_range
    assign range_mask[gi] = (WW'(gi) < WW'(n_eff));
  end

  logic  a_ok, b_ok;
  node_t ia, ib;

  assign a_ok = (in_a != '0) && (WW'(in_a) <= WW'(n_eff));
  assign b_ok = (in_b != '0) && (WW'(in_b) <= WW'(n_eff));
  assign ia   = NW'(in_a - NODE_W'(1));
  assign ib   = NW'(in_b - NODE_W'(1));

  // ---------------------------------------------------------------------------
  // Shared chunk search: lowest set bit of one eight-bit chunk per cycle.
  // Scans unvisited nodes between walks, pending neighbors during a walk.
  // ---------------------------------------------------------------------------
  logic [NC-1:0][CK-1:0] src_chunks;
  logic [CIW-1:0]        src_idx;
  logic [CK-1:0]         chunk;
  logic [PBW-1:0]        pos;
  logic                  hit;
  logic                  last_chunk;
  node_t                 hit_node;
  row_t                  hit_onehot;

  always_comb begin
    if (state_q == S_SCAN) begin
      src_chunks = PW'(cand_q);
      src_idx    = scan_idx_q;
    end else begin
      src_chunks = PW'(~visited_q & range_mask);
      src_idx    = find_idx_q;
    end
  end

  assign chunk = src_chunks[src_idx];

  always_comb begin
    pos = '0;
    for (int i = CK - 1; i >= 0; i--) begin
      if (chunk[i]) begin
        pos = PBW'(i);
      end
    end
  end

  assign hit        = |chunk;
  assign last_chunk = (src_idx == CIW'(NC - 1));
  assign hit_node   = NW'({src_idx, pos});
  assign hit_onehot = row_t'(1) << hit_node;

  // ---------------------------------------------------------------------------
  // Walk stack memory
  // ---------------------------------------------------------------------------
  node_t         stk_mem [MAX_NODES];
  node_t         stk_rd_q;
  logic          stk_we, stk_re;
  logic [CW-1:0] sp_dec;

  assign sp_dec = sp_q - CW'(1);
  assign stk_we = ((state_q == S_FIND) || (state_q == S_SCAN)) && hit;
  assign stk_re = (state_q == S_POP) && (sp_q != '0);

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[sp_q[NW-1:0]] <= hit_node;
    end
    if (stk_re) begin
      stk_rd_q <= stk_mem[sp_dec[NW-1:0]];
    end
  end

  // ---------------------------------------------------------------------------
  // Adjacency memory: one write and one registered read a cycle
  // ---------------------------------------------------------------------------
  row_t  adj_mem [MAX_NODES];
  row_t  adj_rd_q;
  logic  adj_we;
  node_t adj_waddr, adj_raddr;
  row_t  adj_wdata;

  always_comb begin
    adj_we    = 1'b0;
    adj_waddr = a_q;
    adj_raddr = a_q;
    adj_wdata = adj_rd_q | (row_t'(1) << b_q);
    unique case (state_q)
      S_CLEAR: begin
        adj_we    = 1'b1;
        adj_waddr = clr_idx_q;
        adj_wdata = '0;
      end
      S_ADD_WR_A: begin
        adj_we = 1'b1;
      end
      S_ADD_RD_B: begin
        adj_raddr = b_q;
      end
      S_ADD_WR_B: begin
        adj_we    = 1'b1;
        adj_waddr = b_q;
        adj_wdata = adj_rd_q | (row_t'(1) << a_q);
      end
      S_ROW: begin
        adj_raddr = stk_rd_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    adj_rd_q <= adj_mem[adj_raddr];
  end

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_NODE_COUNT) ? APB_DATA_W'(node_count_q) : '0;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      node_count_q <= NODE_COUNT_RST;
      a_q          <= '0;
      b_q          <= '0;
      clr_idx_q    <= '0;
      visited_q    <= '0;
      cand_q       <= '0;
      sp_q         <= '0;
      cnt_q        <= '0;
      find_idx_q   <= '0;
      scan_idx_q   <= '0;
      m_tvalid_q   <= 1'b0;
      m_tdata_q    <= '0;
    end else begin
      if (cfg_wr && (paddr[2] == REG_NODE_COUNT)) begin
        node_count_q <= pwdata[NODE_W-1:0];
      end

      // Drop a taken beat; the emit step hands over the register itself
      if (m_tvalid_q && m_axis_tready && (state_q != S_EMIT)) begin
        m_tvalid_q <= 1'b0;
      end

      unique case (state_q)
        S_CLEAR: begin
          clr_idx_q <= clr_idx_q + NW'(1);
          if (clr_idx_q == NW'(MAX_NODES - 1)) begin
            state_q <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_acc) begin
            unique case (req_e'(in_req))
              REQ_ADD: begin
                a_q <= ia;
                b_q <= ib;
                if (a_ok && b_ok) begin
                  state_q <= S_ADD_RD_A;
                end
              end
              REQ_COUNT: begin
                visited_q  <= '0;
                sp_q       <= '0;
                cnt_q      <= '0;
                find_idx_q <= '0;
                state_q    <= S_FIND;
              end
              REQ_CLEAR: begin
                clr_idx_q <= '0;
                state_q   <= S_CLEAR;
              end
              default: begin
              end
            endcase
          end
        end

        S_ADD_RD_A: state_q <= S_ADD_WR_A;
        S_ADD_WR_A: state_q <= S_ADD_RD_B;
        S_ADD_RD_B: state_q <= S_ADD_WR_B;
        S_ADD_WR_B: state_q <= S_IDLE;

        // Next unvisited node starts a walk: mark, push, count
        S_FIND: begin
          if (hit) begin
            visited_q <= visited_q | hit_onehot;
            sp_q      <= sp_q + CW'(1);
            cnt_q     <= cnt_q + CW'(1);
            state_q   <= S_POP;
          end else if (last_chunk) begin
            state_q <= S_EMIT;
          end else begin
            find_idx_q <= find_idx_q + CIW'(1);
          end
        end

        // Empty stack ends the walk
        S_POP: begin
          if (sp_q == '0) begin
            state_q <= S_FIND;
          end else begin
            sp_q    <= sp_dec;
            state_q <= S_ROW;
          end
        end

        S_ROW: state_q <= S_LOAD;

        // Neighbors not yet visited and inside the nodes in use
        S_LOAD: begin
          cand_q     <= adj_rd_q & ~visited_q & range_mask;
          scan_idx_q <= '0;
          state_q    <= S_SCAN;
        end

        S_SCAN: begin
          if (hit) begin
            visited_q <= visited_q | hit_onehot;
            cand_q    <= cand_q & ~hit_onehot;
            sp_q      <= sp_q + CW'(1);
          end else if (last_chunk) begin
            state_q <= S_POP;
          end else begin
            scan_idx_q <= scan_idx_q + CIW'(1);
          end
        end

        // Hold the count until the output register is free
        S_EMIT: begin
          if (!m_tvalid_q || m_axis_tready) begin
            m_tdata_q  <= COUNT_W'(cnt_q);
            m_tvalid_q <= 1'b1;
            state_q    <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = M_TDATA_W'(m_tdata_q);

`ifndef SYNTH
  // Stack never grows past one entry per node
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= CW'(MAX_NODES))
    else $error("walk stack depth above MAX_NODES");

  // A result beat appears only out of the emit step
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_q) |-> ($past(state_q) == S_EMIT))
    else $error("result beat raised outside emit");

  // No more walks than nodes in use
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (WW'(cnt_q) <= WW'(n_eff)))
    else $error("component count above nodes in use");

  // Visited marks only accumulate while a row is scanned
  a_visit_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |=> ((visited_q & $past(visited_q)) == $past(visited_q)))
    else $error("visited mark lost during scan");
`endif

endmodule

FILE: sim/ccc_result_checker.sv
// Result checker for the connected component counter: follows the request,
// result and register channels, predicts every component count and compares.
// Depends on ccc_pkg.
module ccc_result_checker
  import ccc_pkg::*;
#(
  parameter int unsigned NODES = MAX_NODES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  // [1:0] req_type, [8:2] node_a, [15:9] node_b
  input  logic [S_TDATA_W-1:0]   s_tdata_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  // [6:0] component_count, [7] zero
  input  logic [M_TDATA_W-1:0]   m_tdata_i,
  input  logic                   psel_i,
  input  logic                   penable_i,
  input  logic                   pwrite_i,
  input  logic [APB_ADDR_W-1:0]  paddr_i,
  input  logic [APB_DATA_W-1:0]  pwdata_i,
  input  logic [APB_DATA_W-1:0]  prdata_i,
  input  logic                   pready_i,
  output int                     fail_count_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PRINTED = 40;

  logic [NODES-1:0]   graph_rows [NODES];
  logic [NODE_W-1:0]  node_count;
  logic [COUNT_W-1:0] expected_counts [$];

  task automatic report_mismatch(input string what);
    fail_count_o++;
    if (fail_count_o <= MAX_PRINTED) $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // Flood each unvisited node's component; the walk order does not change the total.
  function automatic logic [COUNT_W-1:0] count_components(input logic [NODE_W-1:0] cfg);
    int unsigned      n;
    int unsigned      walks;
    logic [NODES-1:0] in_use;
    logic [NODES-1:0] seen;
    logic [NODES-1:0] frontier;
    logic [NODES-1:0] reach;
    n = (cfg > NODES) ? NODES : cfg;
    in_use = '0;
    for (int i = 0; i < n; i++) in_use[i] = 1'b1;
    seen  = '0;
    walks = 0;
    for (int k = 0; k < n; k++) begin
      if (!seen[k]) begin
        walks++;
        frontier    = '0;
        frontier[k] = 1'b1;
        seen[k]     = 1'b1;
        while (frontier != '0) begin
          reach = '0;
          for (int u = 0; u < n; u++) begin
            if (frontier[u]) reach |= graph_rows[u];
          end
          // edges to nodes beyond the count in use are kept but not followed
          frontier = reach & in_use & ~seen;
          seen |= frontier;
        end
      end
    end
    return COUNT_W'(walks);
  endfunction

  task automatic apply_request(input logic [S_TDATA_W-1:0] beat);
    logic [REQ_W-1:0]  req;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic [NODE_W-1:0] n;
    req = beat[REQ_W-1:0];
    a   = beat[REQ_W +: NODE_W];
    b   = beat[REQ_W+NODE_W +: NODE_W];
    n   = (node_count > NODES) ? NODE_W'(NODES) : node_count;
    case (req)
      REQ_ADD: begin
        if (a != '0 && b != '0 && a <= n && b <= n) begin
          graph_rows[a-1][b-1] = 1'b1;
          graph_rows[b-1][a-1] = 1'b1;
        end
      end
      REQ_COUNT: begin
        // append at the tail, results come back in request order
        expected_counts = {expected_counts, count_components(node_count)};
      end
      REQ_CLEAR: begin
        for (int r = 0; r < NODES; r++) graph_rows[r] = '0;
      end
      default: ;
    endcase
  endtask

  task automatic check_result(input logic [M_TDATA_W-1:0] beat);
    logic [COUNT_W-1:0] want;
    if (expected_counts.size() == 0) begin
      report_mismatch($sformatf("count beat 0x%02h with no request pending", beat));
      return;
    end
    want = expected_counts.pop_front();
    if (beat[COUNT_W-1:0] !== want)
      report_mismatch($sformatf("component_count %0d, want %0d", beat[COUNT_W-1:0], want));
    if (beat[M_TDATA_W-1:COUNT_W] !== '0)
      report_mismatch($sformatf("pad bits of count beat not zero: 0x%02h", beat));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NODES; r++) graph_rows[r] = '0;
      node_count = NODE_COUNT_RST;
      expected_counts.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) check_result(m_tdata_i);
      // a request in the same beat as a write still sees the old node count
      if (s_tvalid_i && s_tready_i) apply_request(s_tdata_i);
      if (psel_i && penable_i && pready_i && paddr_i[2] == REG_NODE_COUNT) begin
        if (pwrite_i) begin
          node_count = pwdata_i[NODE_W-1:0];
        end else if (prdata_i !== APB_DATA_W'(node_count)) begin
          report_mismatch($sformatf("node_count read 0x%0h, want 0x%0h", prdata_i,
                                    node_count));
        end
      end
      pending_o = expected_counts.size();
    end
  end

endmodule

FILE: sim/connected_component_counter_top_test.sv
// Top of the connected component counter testbench: clock, reset, request
// stream, register traffic and verdict. Depends on ccc_pkg, the block and
// ccc_result_checker.
module connected_component_counter_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ccc_pkg::*;

  localparam time         CLK_PERIOD   = 20ns;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned TARGET_ITEMS = 1350;
  // Worst case near 1400 beats x (a full-graph count + long stalls), taken a few times over
  localparam longint unsigned CYCLE_LIMIT = 5_000_000;
  // Longest silent request is a clear
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned DRAIN_CYCLES  = 200;

  // Request code the block must drop without a trace
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata;   // [1:0] req_type, [8:2] node_a, [15:9] node_b
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [M_TDATA_W-1:0]   m_axis_tdata;   // [6:0] component_count, [7] zero
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_ADDR_W-1:0]  paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  int              fail_total;
  int              open_counts;
  longint unsigned cycle_count;
  int unsigned     useful_items;
  int unsigned     nodes_live;   // nodes in use, clamped to MAX_NODES
  bit              gapless;      // stretch of back-to-back requests

  connected_component_counter_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  ccc_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .fail_count_o (fail_total),
    .pending_o    (open_counts)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Watchdog: a hang anywhere ends the run as a failure
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side back-pressure: mostly short stalls, a few long ones, and now
  // and then a long stretch of steady ready so results drain at full rate.
  initial begin
    int run_len;
    int stall_len;
    int pick;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      m_axis_tready = 1'b1;
      repeat (run_len) @(negedge clk_i);
      pick = $urandom_range(0, 99);
      stall_len = (pick < 45) ? 0 : (pick < 85) ? $urandom_range(1, 4) : $urandom_range(10, 60);
      if (stall_len > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall_len) @(negedge clk_i);
      end
    end
  end

  // Gap before the next request beat; zero throughout a gapless stretch
  function automatic int unsigned next_gap();
    int unsigned pick;
    if (gapless) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one request beat, hold it until taken, then idle for a random gap.
  // Entered and left at a falling edge.
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [NODE_W-1:0] a,
                              input logic [NODE_W-1:0] b);
    int unsigned gap;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {b, a, req};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    gap = next_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Drop the request stream, wait out every pending count, then let a
  // silent add or clear finish before touching the register.
  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (open_counts != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Setup cycle, then access cycle held until pready
  task automatic apb_access(input logic is_write, input logic [APB_DATA_W-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = is_write;
    paddr   = {REG_NODE_COUNT, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Write node_count with random junk above the field, then read it back
  task automatic set_node_count(input logic [NODE_W-1:0] value);
    logic [APB_DATA_W-1:0] word;
    word = $urandom;
    word[NODE_W-1:0] = value;
    apb_access(1'b1, word);
    apb_access(1'b0, '0);
    nodes_live = (value > MAX_NODES_DEF) ? MAX_NODES_DEF : value;
  endtask

  // Endpoint the block must drop: zero or above the nodes in use
  function automatic logic [NODE_W-1:0] stray_node();
    if ($urandom_range(0, 2) == 0) return '0;
    return NODE_W'($urandom_range(nodes_live + 1, 127));
  endfunction

  // Pick a node_count: extremes often, small graphs mostly, full size sometimes
  function automatic logic [NODE_W-1:0] pick_node_count();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5)  return '0;
    if (pick < 10) return NODE_W'($urandom_range(65, 127));
    if (pick < 20) return NODE_W'(MAX_NODES_DEF);
    if (pick < 28) return NODE_W'(1);
    if (pick < 85) return NODE_W'($urandom_range(2, 16));
    return NODE_W'($urandom_range(17, 63));
  endfunction

  // One phase of random traffic on the current node count: mostly legal
  // edges and counts, some clears, plus dropped edges, unused codes and raw noise.
  task automatic random_phase();
    int unsigned phase_len;
    int unsigned pick;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    phase_len = $urandom_range(10, 60);
    gapless   = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 1) == 0) begin
      send_request(REQ_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
      useful_items++;
    end
    repeat (phase_len) begin
      pick = $urandom_range(0, 99);
      if (pick < 60 && nodes_live > 0) begin
        a = NODE_W'($urandom_range(1, nodes_live));
        b = NODE_W'($urandom_range(1, nodes_live));
        send_request(REQ_ADD, a, b);
        useful_items++;
      end else if (pick < 78) begin
        send_request(REQ_COUNT, NODE_W'($urandom), NODE_W'($urandom));
        useful_items++;
      end else if (pick < 82) begin
        send_request(REQ_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
        useful_items++;
      end else if (pick < 90 || nodes_live == 0) begin
        // one or both endpoints out of range
        a = ($urandom_range(0, 1) == 0 || nodes_live == 0) ? stray_node()
                                                           : NODE_W'($urandom_range(1, nodes_live));
        b = stray_node();
        if ($urandom_range(0, 1) == 0) send_request(REQ_ADD, a, b);
        else send_request(REQ_ADD, b, a);
        useful_items++;
      end else if (pick < 95) begin
        send_request(REQ_UNUSED, NODE_W'($urandom), NODE_W'($urandom));
        useful_items++;
      end else begin
        send_request(REQ_W'($urandom), NODE_W'($urandom), NODE_W'($urandom));
        useful_items++;
      end
    end
    // close each phase with a count so every graph built gets checked
    send_request(REQ_COUNT, '0, '0);
    useful_items++;
    gapless = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    useful_items  = 0;
    nodes_live    = MAX_NODES_DEF;
    gapless       = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset value of node_count, read while the matrix sweep is running
    apb_access(1'b0, '0);

    // Directed: empty graph, self loop, dropped endpoints, unused code, clear
    send_request(REQ_COUNT, '0, '0);
    send_request(REQ_ADD, 7'd1, 7'd2);
    send_request(REQ_ADD, 7'd64, 7'd64);
    send_request(REQ_ADD, 7'd0, 7'd5);
    send_request(REQ_ADD, 7'd5, 7'd0);
    send_request(REQ_ADD, 7'd65, 7'd3);
    send_request(REQ_ADD, 7'd127, 7'd127);
    send_request(REQ_ADD, 7'd1, 7'd64);
    send_request(REQ_UNUSED, 7'd1, 7'd3);
    send_request(REQ_COUNT, '0, '0);
    send_request(REQ_CLEAR, '0, '0);
    send_request(REQ_COUNT, '0, '0);
    send_request(REQ_ADD, 7'd10, 7'd11);
    send_request(REQ_ADD, 7'd3, 7'd4);

    // Shrink the graph: the stored edge from node 10 to node 11 must be kept but not followed
    wait_idle();
    set_node_count(7'd10);
    send_request(REQ_COUNT, '0, '0);
    send_request(REQ_ADD, 7'd10, 7'd11);
    send_request(REQ_ADD, 7'd1, 7'd10);
    send_request(REQ_COUNT, '0, '0);

    // No nodes at all: count is zero and every edge drops
    wait_idle();
    set_node_count('0);
    send_request(REQ_COUNT, '0, '0);
    send_request(REQ_ADD, 7'd1, 7'd1);

    // Oversized node count acts as the full graph
    wait_idle();
    set_node_count(7'd127);
    send_request(REQ_COUNT, '0, '0);
    send_request(REQ_ADD, 7'd64, 7'd63);
    send_request(REQ_COUNT, '0, '0);

    // Single node
    wait_idle();
    set_node_count(7'd1);
    send_request(REQ_ADD, 7'd1, 7'd1);
    send_request(REQ_COUNT, '0, '0);
    useful_items = 25;

    // Random phases; each boundary holds the stream until every count is back
    while (useful_items < TARGET_ITEMS) begin
      wait_idle();
      set_node_count(pick_node_count());
      random_phase();
    end

    s_axis_tvalid = 1'b0;
    while (open_counts != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_total == 0 && open_counts == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
